// ===== rtl/core/scrt_pkg.sv =====
`default_nettype none

package scrt_pkg;

  localparam int MAX_LEN = 256;
  localparam int LEN_W   = $clog2(MAX_LEN + 1);
  localparam int ADDR_W  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int COL_W   = LEN_W / 2 + 1;
  localparam int SQ_W    = 2 * COL_W;
  localparam int ROW_W   = LEN_W;
  localparam int IDX_W   = LEN_W + COL_W;
  localparam int MODE_W  = 2;

  localparam logic [MODE_W-1:0] MODE_TEXT   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_CIPHER = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SPACED = 2'd2;

  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_READ = 1'b1;

  localparam logic [7:0] CHAR_SPACE = 8'h20;

  typedef struct packed {
    logic       cmd;
    logic [7:0] in_byte;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_output;
    logic       none_left;
    logic       overflowed;
  } out_item_t;

  typedef struct packed {
    logic push;
    logic read;
    logic restart;
    logic finish;
    logic reading;
    logic rewind;
  } ctl_cmd_t;

  typedef struct packed {
    logic len_zero;
    logic push_len_zero;
    logic read_last;
  } dp_stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/scrt_ram.sv =====
`default_nettype none

module scrt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                                    clk,
  input  wire logic                                    we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                        wdata,
  input  wire logic                                    re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== rtl/core/scrt_ctrl.sv =====
`default_nettype none

module scrt_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic             in_cmd,
  input  wire logic             in_end,
  input  wire logic             cfg_we,
  input  wire scrt_pkg::dp_stat_t stat,
  output scrt_pkg::ctl_cmd_t    ctl,
  output logic                  busy
);

  localparam logic [1:0] PH_LOADING = 2'd0;
  localparam logic [1:0] PH_READING = 2'd1;
  localparam logic [1:0] PH_DONE    = 2'd2;

  logic [1:0] phase_r, phase_nxt;
  logic       busy_r;
  logic       accept;

  assign accept = start & ~busy_r;
  assign busy   = busy_r;

  always_comb begin
    ctl.push    = accept & (in_cmd == scrt_pkg::CMD_PUSH);
    ctl.read    = accept & (in_cmd == scrt_pkg::CMD_READ);
    ctl.restart = ctl.push & (phase_r != PH_LOADING);
    ctl.finish  = ctl.push & in_end;
    ctl.reading = (phase_r == PH_READING);
    ctl.rewind  = cfg_we & (phase_r != PH_LOADING) & ~stat.len_zero;
  end

  always_comb begin
    phase_nxt = phase_r;
    priority if (ctl.rewind) begin
      phase_nxt = PH_READING;
    end else if (ctl.finish) begin
      phase_nxt = stat.push_len_zero ? PH_DONE : PH_READING;
    end else if (ctl.push) begin
      phase_nxt = PH_LOADING;
    end else if (ctl.read && ctl.reading && stat.read_last) begin
      phase_nxt = PH_DONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_LOADING;
      busy_r  <= 1'b1;
    end else begin
      phase_r <= phase_nxt;
      busy_r  <= 1'b0;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/scrt_datapath.sv =====
`default_nettype none

module scrt_datapath (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic [7:0]                    in_byte,
  input  wire logic                          cfg_we,
  input  wire logic [scrt_pkg::MODE_W-1:0]   cfg_wdata,
  input  wire scrt_pkg::ctl_cmd_t            ctl,
  output scrt_pkg::dp_stat_t                 stat,
  output logic                               out_valid,
  output scrt_pkg::out_item_t                out_item
);

  logic [scrt_pkg::LEN_W-1:0]  len_r, len_base, len_nxt;
  logic [scrt_pkg::COL_W-1:0]  cols_r, cols_base, cols_nxt;
  logic [scrt_pkg::SQ_W-1:0]   sq_r, sq_base, sq_nxt;
  logic [scrt_pkg::COL_W-1:0]  rows_r, rows_nxt, rows_calc;
  logic [scrt_pkg::ROW_W-1:0]  rd_row_r, rd_row_nxt;
  logic [scrt_pkg::COL_W-1:0]  rd_col_r, rd_col_nxt;
  logic                        drop_r, drop_base, drop_nxt;
  logic [scrt_pkg::MODE_W-1:0] mode_r, mode_nxt;
  logic                        out_valid_r;
  logic                        none_r, pad_r, last_r, ovf_r;

  logic                        is_upper, is_lower, is_digit, keep, can_store, wr_en, grow;
  logic [7:0]                  wr_byte;
  logic [scrt_pkg::SQ_W-1:0]   len_ext, sq_less;

  logic [scrt_pkg::ROW_W:0]    row_inc;
  logic [scrt_pkg::COL_W:0]    col_inc;
  logic [scrt_pkg::IDX_W-1:0]  grid_idx;
  logic                        sep, row_end, col_end, pad, last;
  logic [scrt_pkg::ADDR_W-1:0] rd_addr;
  logic [7:0]                  ram_q;

  always_comb begin
    is_upper  = (in_byte >= 8'h41) && (in_byte <= 8'h5a);
    is_lower  = (in_byte >= 8'h61) && (in_byte <= 8'h7a);
    is_digit  = (in_byte >= 8'h30) && (in_byte <= 8'h39);
    keep      = is_upper | is_lower | is_digit;
    wr_byte   = is_upper ? (in_byte | 8'h20) : in_byte;

    len_base  = ctl.restart ? '0 : len_r;
    cols_base = ctl.restart ? '0 : cols_r;
    sq_base   = ctl.restart ? '0 : sq_r;
    drop_base = ctl.restart ? 1'b0 : drop_r;

    can_store = (len_base < scrt_pkg::LEN_W'(scrt_pkg::MAX_LEN));
    wr_en     = ctl.push & keep & can_store;
    len_nxt   = wr_en ? (len_base + 1'b1) : len_base;
    len_ext   = scrt_pkg::SQ_W'(len_nxt);
    grow      = wr_en & (len_ext > sq_base);
    cols_nxt  = grow ? (cols_base + 1'b1) : cols_base;
    sq_nxt    = grow ? (sq_base + scrt_pkg::SQ_W'({cols_base, 1'b0}) + 1'b1) : sq_base;
    drop_nxt  = drop_base | (ctl.push & keep & ~can_store);

    // Length lies between (c-1)^2 and c^2, so the row count is c or c-1.
    sq_less   = sq_nxt - scrt_pkg::SQ_W'(cols_nxt);
    if (cols_nxt == '0) begin
      rows_calc = '0;
    end else if (len_ext > sq_less) begin
      rows_calc = cols_nxt;
    end else begin
      rows_calc = cols_nxt - 1'b1;
    end
  end

  always_comb begin
    row_inc  = scrt_pkg::ROW_W'(rd_row_r) + 1'b1;
    col_inc  = scrt_pkg::COL_W'(rd_col_r) + 1'b1;
    grid_idx = scrt_pkg::IDX_W'(rd_row_r) * scrt_pkg::IDX_W'(cols_r)
             + scrt_pkg::IDX_W'(rd_col_r);
    sep      = (rd_row_r >= scrt_pkg::ROW_W'(rows_r));
    row_end  = (row_inc >= (scrt_pkg::ROW_W + 1)'(rows_r));
    col_end  = (col_inc >= (scrt_pkg::COL_W + 1)'(cols_r));
    if (mode_r == scrt_pkg::MODE_TEXT) begin
      rd_addr = rd_row_r[scrt_pkg::ADDR_W-1:0];
      pad     = (rd_row_r >= len_r);
      last    = (row_inc >= (scrt_pkg::ROW_W + 1)'(len_r));
    end else begin
      rd_addr = grid_idx[scrt_pkg::ADDR_W-1:0];
      pad     = sep | (grid_idx >= scrt_pkg::IDX_W'(len_r));
      last    = ~sep & row_end & col_end;
    end
  end

  assign stat.len_zero      = (len_r == '0);
  assign stat.push_len_zero = (len_nxt == '0);
  assign stat.read_last     = last;

  always_comb begin
    rows_nxt   = rows_r;
    rd_row_nxt = rd_row_r;
    rd_col_nxt = rd_col_r;
    mode_nxt   = cfg_we ? cfg_wdata : mode_r;
    priority if (ctl.rewind) begin
      rd_row_nxt = '0;
      rd_col_nxt = '0;
    end else if (ctl.push) begin
      if (ctl.finish) begin
        rows_nxt   = rows_calc;
        rd_row_nxt = '0;
        rd_col_nxt = '0;
      end else if (ctl.restart) begin
        rows_nxt   = '0;
        rd_row_nxt = '0;
        rd_col_nxt = '0;
      end
    end else if (ctl.read && ctl.reading) begin
      if (mode_r == scrt_pkg::MODE_TEXT) begin
        rd_row_nxt = row_inc[scrt_pkg::ROW_W-1:0];
      end else if (sep) begin
        rd_row_nxt = '0;
        rd_col_nxt = col_inc[scrt_pkg::COL_W-1:0];
      end else if (row_end && !col_end && mode_r != scrt_pkg::MODE_SPACED) begin
        rd_row_nxt = '0;
        rd_col_nxt = col_inc[scrt_pkg::COL_W-1:0];
      end else begin
        rd_row_nxt = row_inc[scrt_pkg::ROW_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r       <= '0;
      cols_r      <= '0;
      sq_r        <= '0;
      rows_r      <= '0;
      rd_row_r    <= '0;
      rd_col_r    <= '0;
      drop_r      <= 1'b0;
      mode_r      <= scrt_pkg::MODE_CIPHER;
      out_valid_r <= 1'b0;
    end else begin
      if (ctl.push) begin
        len_r  <= len_nxt;
        cols_r <= cols_nxt;
        sq_r   <= sq_nxt;
        drop_r <= drop_nxt;
      end
      rows_r      <= rows_nxt;
      rd_row_r    <= rd_row_nxt;
      rd_col_r    <= rd_col_nxt;
      mode_r      <= mode_nxt;
      out_valid_r <= ctl.read;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.read) begin
      none_r <= ~ctl.reading;
      pad_r  <= pad;
      last_r <= ctl.reading & last;
      ovf_r  <= drop_r;
    end
  end

  scrt_ram #(
    .WIDTH (8),
    .DEPTH (scrt_pkg::MAX_LEN)
  ) u_text_store (
    .clk   (clk),
    .we    (wr_en),
    .waddr (len_base[scrt_pkg::ADDR_W-1:0]),
    .wdata (wr_byte),
    .re    (ctl.read),
    .raddr (rd_addr),
    .rdata (ram_q)
  );

  assign out_valid = out_valid_r;

  always_comb begin
    out_item.last_of_output = last_r;
    out_item.none_left      = none_r;
    out_item.overflowed     = ovf_r;
    if (none_r) begin
      out_item.out_byte = 8'h00;
    end else if (pad_r) begin
      out_item.out_byte = scrt_pkg::CHAR_SPACE;
    end else begin
      out_item.out_byte = ram_q;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/square_columnar_transposer_unit.sv =====
// Latency: a read beat gives its result on out_item, with out_valid high, in the cycle after
// acceptance; a push beat gives no result.
// Throughput: one beat per cycle while busy is low; the result waits on the text store's registered read.
// Reset: synchronous, active low; busy is high for the first cycle after reset is released.
// The text store is not cleared. The receiver cannot stall the result strobe.
`default_nettype none

module square_columnar_transposer_unit (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  output logic                             busy,
  input  wire scrt_pkg::in_item_t          in_item,
  input  wire logic                        cfg_we,
  input  wire logic [scrt_pkg::MODE_W-1:0] cfg_wdata,
  output logic                             out_valid,
  output scrt_pkg::out_item_t              out_item
);

  scrt_pkg::ctl_cmd_t ctl;
  scrt_pkg::dp_stat_t stat;

  scrt_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .in_cmd (in_item.cmd),
    .in_end (in_item.end_of_text),
    .cfg_we (cfg_we),
    .stat   (stat),
    .ctl    (ctl),
    .busy   (busy)
  );

  scrt_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_byte   (in_item.in_byte),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .ctl       (ctl),
    .stat      (stat),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire

// ===== rtl/core/scrt_checker.sv =====
`default_nettype none

module scrt_checker (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        start,
  input wire logic                        busy,
  input wire scrt_pkg::in_item_t          in_item,
  input wire logic                        out_valid,
  input wire scrt_pkg::out_item_t         out_item
);

  logic read_beat;

  assign read_beat = start & ~busy & (in_item.cmd == scrt_pkg::CMD_READ);

  // Every accepted read beat yields exactly one result in the next cycle.
  a_read_answered: assert property (@(posedge clk) disable iff (!rst_n)
    read_beat |=> out_valid)
    else $error("read beat not answered");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !read_beat |=> !out_valid)
    else $error("result without a read beat");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.none_left) |-> (out_item.out_byte == 8'h00))
    else $error("non-zero byte with nothing left");

  a_last_has_byte: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.last_of_output) |-> !out_item.none_left)
    else $error("final byte flagged as unavailable");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> (!out_valid && busy))
    else $error("activity straight after reset");

endmodule

bind square_columnar_transposer_unit scrt_checker u_scrt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_item  (out_item)
);

`default_nettype wire

// ===== dv/tb.sv =====
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int BEAT_TARGET = 1350;
  localparam int QUIET_LIMIT = 2000;
  localparam int SHOWN_MISMATCHES = 10;
  localparam logic [scrt_pkg::MODE_W-1:0] MODE_UNLISTED = 2'd3;

  typedef enum logic [1:0] {LOADING, READING, FINISHED} msg_phase_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  scrt_pkg::in_item_t in_item = '0;
  logic cfg_we = 1'b0;
  logic [scrt_pkg::MODE_W-1:0] cfg_wdata = '0;
  logic out_valid;
  scrt_pkg::out_item_t out_item;

  logic [7:0] stored_text [scrt_pkg::MAX_LEN];
  logic [scrt_pkg::LEN_W-1:0] text_len;
  logic [scrt_pkg::COL_W-1:0] cols;
  logic [scrt_pkg::SQ_W-1:0] cols_sq;
  logic [scrt_pkg::ROW_W-1:0] rows;
  logic [scrt_pkg::ROW_W-1:0] row_ptr;
  logic [scrt_pkg::COL_W-1:0] col_ptr;
  msg_phase_t msg_phase;
  logic dropped;
  logic [scrt_pkg::MODE_W-1:0] mode;

  scrt_pkg::out_item_t expected_bytes[$];
  int beats_sent = 0;
  int mismatches = 0;
  int quiet_cycles = 0;
  bit steady = 1'b0;

  square_columnar_transposer_unit dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_item(in_item),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .out_valid(out_valid),
    .out_item(out_item)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void clear_message();
    text_len = '0;
    cols = '0;
    cols_sq = '0;
    rows = '0;
    col_ptr = '0;
    row_ptr = '0;
    dropped = 1'b0;
    msg_phase = LOADING;
  endfunction

  function automatic void close_message();
    col_ptr = '0;
    row_ptr = '0;
    if (text_len == 0) begin
      rows = '0;
      msg_phase = FINISHED;
    end else begin
      rows = scrt_pkg::ROW_W'((int'(text_len) + int'(cols) - 1) / int'(cols));
      msg_phase = READING;
    end
  endfunction

  function automatic void load_byte(logic [7:0] raw, logic eot);
    logic [7:0] c;
    logic keep;
    c = raw;
    keep = 1'b0;
    if (msg_phase != LOADING) clear_message();
    if (c >= "A" && c <= "Z") begin
      c = c + 8'h20;
      keep = 1'b1;
    end else if ((c >= "a" && c <= "z") || (c >= "0" && c <= "9")) begin
      keep = 1'b1;
    end
    if (keep) begin
      if (text_len < scrt_pkg::MAX_LEN) begin
        stored_text[text_len[scrt_pkg::ADDR_W-1:0]] = c;
        text_len = text_len + 1'b1;
        if (text_len > cols_sq) begin
          cols = cols + 1'b1;
          cols_sq = cols * cols;
        end
      end else begin
        dropped = 1'b1;
      end
    end
    if (eot) close_message();
  endfunction

  function automatic logic [7:0] grid_char(int idx);
    return (idx < int'(text_len)) ? stored_text[idx] : scrt_pkg::CHAR_SPACE;
  endfunction

  function automatic scrt_pkg::out_item_t next_output_byte();
    scrt_pkg::out_item_t r;
    r = '0;
    if (msg_phase != READING) begin
      r.none_left = 1'b1;
    end else if (mode == scrt_pkg::MODE_TEXT) begin
      r.out_byte = grid_char(int'(row_ptr));
      row_ptr = row_ptr + 1'b1;
      if (row_ptr >= text_len) begin
        r.last_of_output = 1'b1;
        msg_phase = FINISHED;
      end
    end else if (row_ptr >= rows) begin
      r.out_byte = scrt_pkg::CHAR_SPACE;
      row_ptr = '0;
      col_ptr = col_ptr + 1'b1;
    end else begin
      r.out_byte = grid_char(int'(row_ptr) * int'(cols) + int'(col_ptr));
      row_ptr = row_ptr + 1'b1;
      if (row_ptr >= rows) begin
        if (int'(col_ptr) + 1 >= int'(cols)) begin
          r.last_of_output = 1'b1;
          msg_phase = FINISHED;
        end else if (mode != scrt_pkg::MODE_SPACED) begin
          row_ptr = '0;
          col_ptr = col_ptr + 1'b1;
        end
      end
    end
    r.overflowed = dropped;
    return r;
  endfunction

  function automatic void set_mode(logic [scrt_pkg::MODE_W-1:0] v);
    mode = v;
    if (msg_phase != LOADING && text_len != 0) begin
      col_ptr = '0;
      row_ptr = '0;
      msg_phase = READING;
    end
  endfunction

  function automatic int readout_length();
    if (msg_phase != READING) return 0;
    if (mode == scrt_pkg::MODE_TEXT) return int'(text_len);
    if (mode == scrt_pkg::MODE_SPACED) return int'(rows) * int'(cols) + int'(cols) - 1;
    return int'(rows) * int'(cols);
  endfunction

  function automatic logic [7:0] random_text_byte(bit kept_only);
    int pick;
    pick = kept_only ? $urandom_range(6) : $urandom_range(9);
    if (pick < 3) return 8'("a" + $urandom_range(25));
    if (pick < 5) return 8'("A" + $urandom_range(25));
    if (pick < 7) return 8'("0" + $urandom_range(9));
    return 8'($urandom_range(255));
  endfunction

  task automatic note_mismatch(string what);
    mismatches++;
    if (mismatches <= SHOWN_MISMATCHES) $display("%0t: %s", $time, what);
  endtask

  task automatic send_beat(logic cmd, logic [7:0] data, logic eot);
    scrt_pkg::in_item_t item;
    item.cmd = cmd;
    item.in_byte = data;
    item.end_of_text = eot;
    if (!steady && $urandom_range(99) < 16) begin
      start <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
    start <= 1'b1;
    in_item <= item;
    do @(posedge clk); while (busy);
    beats_sent++;
    if (cmd == scrt_pkg::CMD_READ) expected_bytes.push_back(next_output_byte());
    else load_byte(data, eot);
  endtask

  task automatic push_text(string s, bit close);
    for (int i = 0; i < s.len(); i++)
      send_beat(scrt_pkg::CMD_PUSH, s[i], close && i == s.len() - 1);
  endtask

  task automatic read_bytes(int n);
    repeat (n) send_beat(scrt_pkg::CMD_READ, 8'($urandom_range(255)), 1'($urandom_range(1)));
  endtask

  task automatic write_mode(logic [scrt_pkg::MODE_W-1:0] v);
    start <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    cfg_wdata <= scrt_pkg::MODE_W'($urandom_range(3));
    set_mode(v);
  endtask

  task automatic test_no_byte_available();
    read_bytes(1);
    push_text("?!", 1'b1);
    read_bytes(2);
    write_mode(scrt_pkg::MODE_TEXT);
    read_bytes(1);
    push_text("Z", 1'b1);
    read_bytes(2);
  endtask

  task automatic test_character_classes();
    logic [7:0] probe [15];
    probe = '{8'h00, 8'h2f, 8'h30, 8'h39, 8'h3a, 8'h40, 8'h41, 8'h5a,
              8'h5b, 8'h60, 8'h61, 8'h7a, 8'h7b, 8'hff, 8'hc1};
    write_mode(scrt_pkg::MODE_SPACED);
    for (int i = 0; i < 15; i++) send_beat(scrt_pkg::CMD_PUSH, probe[i], i == 14);
    read_bytes(9);
  endtask

  task automatic test_output_modes();
    write_mode(scrt_pkg::MODE_TEXT);
    read_bytes(7);
    write_mode(MODE_UNLISTED);
    read_bytes(7);
    write_mode(scrt_pkg::MODE_CIPHER);
    read_bytes(3);
    write_mode(scrt_pkg::MODE_CIPHER);
    read_bytes(7);
    push_text("ab", 1'b0);
    read_bytes(1);
    write_mode(scrt_pkg::MODE_SPACED);
    push_text("c", 1'b1);
    read_bytes(6);
  endtask

  task automatic test_full_buffer();
    steady = 1'b1;
    repeat (scrt_pkg::MAX_LEN + 40)
      send_beat(scrt_pkg::CMD_PUSH, random_text_byte(1'b1), 1'b0);
    send_beat(scrt_pkg::CMD_PUSH, "q", 1'b1);
    read_bytes(readout_length() + 1);
    write_mode(scrt_pkg::MODE_TEXT);
    read_bytes(40);
    steady = 1'b0;
  endtask

  task automatic test_random_messages();
    int len;
    int n;
    bit noise_only;
    while (beats_sent < BEAT_TARGET) begin
      len = ($urandom_range(99) < 4) ? $urandom_range(300, 150) : $urandom_range(40, 1);
      noise_only = ($urandom_range(19) == 0);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(19) == 0) read_bytes(1);
        send_beat(scrt_pkg::CMD_PUSH, noise_only ? (8'h80 | 8'($urandom_range(127)))
                                                 : random_text_byte(1'b0), i == len - 1);
      end
      if ($urandom_range(4) == 0) write_mode(scrt_pkg::MODE_W'($urandom_range(3)));
      n = readout_length();
      if ($urandom_range(6) == 0) begin
        n = $urandom_range(n);
      end else if (n > 2 && $urandom_range(9) == 0) begin
        read_bytes($urandom_range(n - 1, 1));
        write_mode(scrt_pkg::MODE_W'($urandom_range(3)));
        n = readout_length();
      end
      read_bytes(n + $urandom_range(2));
    end
  endtask

  always @(posedge clk) begin
    scrt_pkg::out_item_t want;
    if (rst_n && out_valid !== 1'b0) begin
      if (expected_bytes.size() == 0) begin
        note_mismatch($sformatf("unexpected result beat %h", out_item));
      end else begin
        want = expected_bytes.pop_front();
        if (out_valid !== 1'b1 || out_item.out_byte !== want.out_byte ||
            out_item.last_of_output !== want.last_of_output ||
            out_item.none_left !== want.none_left ||
            out_item.overflowed !== want.overflowed)
          note_mismatch($sformatf(
            "byte exp %h got %h, last exp %b got %b, none exp %b got %b, ovf exp %b got %b",
            want.out_byte, out_item.out_byte, want.last_of_output, out_item.last_of_output,
            want.none_left, out_item.none_left, want.overflowed, out_item.overflowed));
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_valid || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    clear_message();
    mode = scrt_pkg::MODE_CIPHER;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    do @(posedge clk); while (busy);
    test_no_byte_available();
    test_character_classes();
    test_output_modes();
    test_full_buffer();
    test_random_messages();
    start <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
